>>> src/vrp_pkg.sv
// Shared types and constants for the vertex rotate and project unit.
// Used by the top level and by its square root and divider pipelines.
// No dependencies.
package vrp_pkg;

    // Field and datapath widths
    localparam int COORD_W  = 16;
    localparam int CFG_W    = 16;
    localparam int ROT_W    = 32;
    localparam int SQ_W     = 64;
    localparam int ROOT_W   = SQ_W / 2;
    localparam int QUO_W    = 42;
    localparam int DEN_W    = 32;
    localparam int LIN_W    = 40;
    localparam int PFRAC    = 14;

    // Projection constants
    localparam int CENTRE_X     = 860;
    localparam int CENTRE_Y     = 460;
    localparam int PERSP_SCALE  = 1000;
    localparam int PERSP_DIST   = 600;
    localparam int STEREO_SCALE = 300;
    localparam int ISO_COS      = 14189;
    localparam int ISO_SIN      = 8192;
    localparam int OBL_KX       = 6905;
    localparam int OBL_KY       = 4408;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_COS_X = 3'd0,
        CFG_SIN_X = 3'd1,
        CFG_COS_Y = 3'd2,
        CFG_SIN_Y = 3'd3,
        CFG_COS_Z = 3'd4,
        CFG_SIN_Z = 3'd5,
        CFG_PAN_X = 3'd6,
        CFG_PAN_Y = 3'd7
    } vrp_cfg_idx_t;

    // Projection modes
    typedef enum logic [1:0] {
        MODE_PERSP   = 2'd0,
        MODE_ISO     = 2'd1,
        MODE_OBLIQUE = 2'd2,
        MODE_STEREO  = 2'd3
    } vrp_mode_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic [1:0]                mode;
    } vrp_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] screen_x;
        logic signed [COORD_W-1:0] screen_y;
        logic                      div_error;
    } vrp_out_t;

    // Pipeline control handed to the sub-pipelines
    typedef struct packed {
        logic advance;
        logic valid;
    } vrp_ctl_t;

    // Rotated point carried through the square root pipeline
    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ROT_W-1:0] z;
        vrp_mode_t               mode;
    } vrp_rot_t;

    // Projection state carried through the divider pipeline
    typedef struct packed {
        logic                    err;
        vrp_mode_t               mode;
        logic                    neg_x;
        logic                    neg_y;
        logic signed [LIN_W-1:0] lin_x;
        logic signed [LIN_W-1:0] lin_y;
    } vrp_div_side_t;

endpackage

>>> src/vrp_isqrt_pipe.sv
// Pipelined integer square root, one result bit per stage.
// Depends on vrp_pkg.
module vrp_isqrt_pipe
    import vrp_pkg::*;
#(
    parameter int SIDE_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  vrp_ctl_t          ctl,
    input  logic [SQ_W-1:0]   radicand,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int STAGES = ROOT_W;
    localparam int REM_W  = ROOT_W + 2;

    logic [SQ_W-1:0]   rad_s  [0:STAGES];
    logic [REM_W-1:0]  rem_s  [0:STAGES];
    logic [ROOT_W-1:0] root_s [0:STAGES];
    logic [SIDE_W-1:0] side_s [0:STAGES];
    logic              vld_s  [0:STAGES];

    assign rad_s[0]  = radicand;
    assign rem_s[0]  = '0;
    assign root_s[0] = '0;
    assign side_s[0] = in_side;
    assign vld_s[0]  = ctl.valid;

    genvar k;
    generate
        for (k = 0; k < STAGES; k++)
        begin : g_stage
            logic [REM_W+1:0]  trial;
            logic [REM_W+1:0]  test;
            logic              ge;
            logic [SQ_W-1:0]   rad_reg;
            logic [REM_W-1:0]  rem_reg;
            logic [ROOT_W-1:0] root_reg;
            logic [SIDE_W-1:0] side_reg;
            logic              vld_reg;

            // Bring down the next two radicand bits and try root*4+1.
            always_comb
            begin
                trial = {rem_s[k], rad_s[k][SQ_W-1 -: 2]};
                test  = {2'b00, root_s[k], 2'b01};
                ge    = (trial >= test);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg <= 1'b0;
                end
                else if (ctl.advance)
                begin
                    vld_reg <= vld_s[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (ctl.advance)
                begin
                    rad_reg  <= rad_s[k] << 2;
                    rem_reg  <= ge ? REM_W'(trial - test) : REM_W'(trial);
                    root_reg <= {root_s[k][ROOT_W-2:0], ge};
                    side_reg <= side_s[k];
                end
            end

            assign rad_s[k+1]  = rad_reg;
            assign rem_s[k+1]  = rem_reg;
            assign root_s[k+1] = root_reg;
            assign side_s[k+1] = side_reg;
            assign vld_s[k+1]  = vld_reg;
        end
    endgenerate

    assign out_valid = vld_s[STAGES];
    assign root      = root_s[STAGES];
    assign out_side  = side_s[STAGES];

endmodule

>>> src/vrp_div_pipe.sv
// Pipelined unsigned restoring divider: two dividends share one divisor,
// one quotient bit per stage. Depends on vrp_pkg.
module vrp_div_pipe
    import vrp_pkg::*;
#(
    parameter int SIDE_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  vrp_ctl_t          ctl,
    input  logic [QUO_W-1:0]  num_a,
    input  logic [QUO_W-1:0]  num_b,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [QUO_W-1:0]  quo_a,
    output logic [QUO_W-1:0]  quo_b,
    output logic [SIDE_W-1:0] out_side
);

    localparam int STAGES = QUO_W;

    logic [QUO_W-1:0]  nq_a_s [0:STAGES];
    logic [QUO_W-1:0]  nq_b_s [0:STAGES];
    logic [DEN_W-1:0]  rem_a_s [0:STAGES];
    logic [DEN_W-1:0]  rem_b_s [0:STAGES];
    logic [DEN_W-1:0]  den_s  [0:STAGES];
    logic [SIDE_W-1:0] side_s [0:STAGES];
    logic              vld_s  [0:STAGES];

    assign nq_a_s[0]  = num_a;
    assign nq_b_s[0]  = num_b;
    assign rem_a_s[0] = '0;
    assign rem_b_s[0] = '0;
    assign den_s[0]   = den;
    assign side_s[0]  = in_side;
    assign vld_s[0]   = ctl.valid;

    genvar k;
    generate
        for (k = 0; k < STAGES; k++)
        begin : g_stage
            logic [DEN_W:0]    trial_a;
            logic [DEN_W:0]    trial_b;
            logic              ge_a;
            logic              ge_b;
            logic [QUO_W-1:0]  nq_a_reg;
            logic [QUO_W-1:0]  nq_b_reg;
            logic [DEN_W-1:0]  rem_a_reg;
            logic [DEN_W-1:0]  rem_b_reg;
            logic [DEN_W-1:0]  den_reg;
            logic [SIDE_W-1:0] side_reg;
            logic              vld_reg;

            // Shift in the next dividend bit and subtract where it fits.
            always_comb
            begin
                trial_a = {rem_a_s[k], nq_a_s[k][QUO_W-1]};
                trial_b = {rem_b_s[k], nq_b_s[k][QUO_W-1]};
                ge_a    = (trial_a >= {1'b0, den_s[k]});
                ge_b    = (trial_b >= {1'b0, den_s[k]});
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg <= 1'b0;
                end
                else if (ctl.advance)
                begin
                    vld_reg <= vld_s[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (ctl.advance)
                begin
                    nq_a_reg  <= {nq_a_s[k][QUO_W-2:0], ge_a};
                    nq_b_reg  <= {nq_b_s[k][QUO_W-2:0], ge_b};
                    rem_a_reg <= ge_a ? DEN_W'(trial_a - {1'b0, den_s[k]})
                                      : DEN_W'(trial_a);
                    rem_b_reg <= ge_b ? DEN_W'(trial_b - {1'b0, den_s[k]})
                                      : DEN_W'(trial_b);
                    den_reg   <= den_s[k];
                    side_reg  <= side_s[k];
                end
            end

            assign nq_a_s[k+1]  = nq_a_reg;
            assign nq_b_s[k+1]  = nq_b_reg;
            assign rem_a_s[k+1] = rem_a_reg;
            assign rem_b_s[k+1] = rem_b_reg;
            assign den_s[k+1]   = den_reg;
            assign side_s[k+1]  = side_reg;
            assign vld_s[k+1]   = vld_reg;
        end
    endgenerate

    assign out_valid = vld_s[STAGES];
    assign quo_a     = nq_a_s[STAGES];
    assign quo_b     = nq_b_s[STAGES];
    assign out_side  = side_s[STAGES];

endmodule

>>> src/vertex_rotate_project_unit.sv
// Top level of the vertex rotate and project unit.
// Depends on vrp_pkg, vrp_isqrt_pipe and vrp_div_pipe.
//
// Channel   Direction  Handshake                 Payload
// in        input      in_valid / in_ready       in_data  (vrp_in_t)
// out       output     out_valid / out_ready     out_data (vrp_out_t)
// cfg       input      cfg_we (no wait)          cfg_addr, cfg_wdata
//
// One item enters per clock unless the output stalls. The pipeline has 8
// rotation and square stages, 32 square root stages, 2 projection setup
// stages, 42 divider stages and the output register. The divider's one
// bit per stage sets the largest share of the depth. Reset clears all
// valid bits and loads the identity rotation with zero pan. When the
// output item is not taken, every stage holds and in_ready is low.
module vertex_rotate_project_unit
    import vrp_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = 14
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  vrp_in_t            in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output vrp_out_t           out_data,
    input  logic               cfg_we,
    input  vrp_cfg_idx_t       cfg_addr,
    input  logic [CFG_W-1:0]   cfg_wdata
);

    localparam int PROD_W    = ROT_W + CFG_W;
    localparam int ROT_SUM_W = PROD_W + 1;
    localparam int NUM_W     = ROT_W + 12;
    localparam int DEN_SW    = DEN_W + 2;
    localparam int LM_W      = ROT_W + 1;
    localparam int LPROD_W   = LM_W + 16;
    localparam int OFF_W     = ROT_W + 3;
    localparam int LSUM_W    = LPROD_W + 1;
    localparam int FIN_W     = QUO_W + 4;
    localparam int ROT_SIDE_W = $bits(vrp_rot_t);
    localparam int DIV_SIDE_W = $bits(vrp_div_side_t);

    localparam logic signed [ROT_SUM_W-1:0] ROUND_BIAS =
        {{(ROT_SUM_W-TRIG_FRAC_BITS){1'b0}}, {TRIG_FRAC_BITS{1'b1}}};
    localparam logic signed [ROT_SUM_W-1:0] ROT_MAX =
        {{(ROT_SUM_W-ROT_W+1){1'b0}}, {(ROT_W-1){1'b1}}};
    localparam logic signed [ROT_SUM_W-1:0] ROT_MIN =
        {{(ROT_SUM_W-ROT_W+1){1'b1}}, {(ROT_W-1){1'b0}}};
    localparam logic signed [LSUM_W-1:0] PBIAS =
        {{(LSUM_W-PFRAC){1'b0}}, {PFRAC{1'b1}}};
    localparam logic signed [FIN_W-1:0] OUT_MAX =
        {{(FIN_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam logic signed [FIN_W-1:0] OUT_MIN =
        {{(FIN_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

    // Truncate a rotation sum toward zero and clamp it to 32 bits.
    function automatic logic signed [ROT_W-1:0] rot_fin(
        input logic signed [ROT_SUM_W-1:0] s);
        logic signed [ROT_SUM_W-1:0] t;
        t = (s < 0) ? s + ROUND_BIAS : s;
        t = t >>> TRIG_FRAC_BITS;
        if (t > ROT_MAX)
            return ROT_MAX[ROT_W-1:0];
        if (t < ROT_MIN)
            return ROT_MIN[ROT_W-1:0];
        return t[ROT_W-1:0];
    endfunction

    // Truncating divide by 2^PFRAC for the linear projections.
    function automatic logic signed [LIN_W-1:0] lin_fin(
        input logic signed [LSUM_W-1:0] s);
        logic signed [LSUM_W-1:0] t;
        t = (s < 0) ? s + PBIAS : s;
        t = t >>> PFRAC;
        return t[LIN_W-1:0];
    endfunction

    // Saturate a screen coordinate to the output width.
    function automatic logic signed [COORD_W-1:0] sat_out(
        input logic signed [FIN_W-1:0] v);
        if (v > OUT_MAX)
            return OUT_MAX[COORD_W-1:0];
        if (v < OUT_MIN)
            return OUT_MIN[COORD_W-1:0];
        return v[COORD_W-1:0];
    endfunction

    // Configuration registers
    logic signed [CFG_W-1:0] cfg_reg [0:7];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[CFG_COS_X] <= CFG_W'(16384);
            cfg_reg[CFG_SIN_X] <= '0;
            cfg_reg[CFG_COS_Y] <= CFG_W'(16384);
            cfg_reg[CFG_SIN_Y] <= '0;
            cfg_reg[CFG_COS_Z] <= CFG_W'(16384);
            cfg_reg[CFG_SIN_Z] <= '0;
            cfg_reg[CFG_PAN_X] <= '0;
            cfg_reg[CFG_PAN_Y] <= '0;
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_addr] <= cfg_wdata;
        end
    end

    logic signed [CFG_W-1:0] cos_x, sin_x, cos_y, sin_y, cos_z, sin_z, pan_x, pan_y;
    assign cos_x = cfg_reg[CFG_COS_X];
    assign sin_x = cfg_reg[CFG_SIN_X];
    assign cos_y = cfg_reg[CFG_COS_Y];
    assign sin_y = cfg_reg[CFG_SIN_Y];
    assign cos_z = cfg_reg[CFG_COS_Z];
    assign sin_z = cfg_reg[CFG_SIN_Z];
    assign pan_x = cfg_reg[CFG_PAN_X];
    assign pan_y = cfg_reg[CFG_PAN_Y];

    // Global advance: every stage moves unless the output item is stuck.
    logic     adv;
    logic     out_valid_reg;
    vrp_out_t out_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // Valid bits of the rotation stages and of the projection setup stages
    logic [7:0] rv_reg;
    logic       d0_valid_reg, d1_valid_reg;
    logic       sq_valid, dv_valid;

    // Rotation stage registers
    logic signed [PROD_W-1:0] s1_ycx_reg, s1_zsx_reg, s1_zcx_reg, s1_ysx_reg;
    logic signed [ROT_W-1:0]  s1_x_reg;
    logic signed [ROT_W-1:0]  s2_x_reg, s2_y1_reg, s2_z1_reg;
    logic signed [PROD_W-1:0] s3_xcy_reg, s3_zsy_reg, s3_zcy_reg, s3_xsy_reg;
    logic signed [ROT_W-1:0]  s3_y1_reg;
    logic signed [ROT_W-1:0]  s4_x1_reg, s4_y1_reg, s4_z_reg;
    logic signed [PROD_W-1:0] s5_xcz_reg, s5_ysz_reg, s5_xsz_reg, s5_ycz_reg;
    logic signed [ROT_W-1:0]  s5_z_reg;
    logic signed [ROT_W-1:0]  s6_x_reg, s6_y_reg, s6_z_reg;
    logic signed [SQ_W-1:0]   s7_sqx_reg, s7_sqy_reg, s7_sqz_reg;
    logic signed [ROT_W-1:0]  s7_x_reg, s7_y_reg, s7_z_reg;
    logic [SQ_W-1:0]          s8_sum_reg;
    vrp_rot_t                 s8_side_reg;
    vrp_mode_t                mode_pipe_reg [1:7];

    logic signed [ROT_W-1:0] in_x, in_y, in_z;
    assign in_x = ROT_W'(in_data.coord_x);
    assign in_y = ROT_W'(in_data.coord_y);
    assign in_z = ROT_W'(in_data.coord_z);

    // Valid bits for the rotation and squaring stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg <= '0;
        end
        else if (adv)
        begin
            rv_reg <= {rv_reg[6:0], in_valid};
        end
    end

    // Rotation about X, Y, Z: products in one stage, sums in the next.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ycx_reg <= in_y * cos_x;
            s1_zsx_reg <= in_z * sin_x;
            s1_zcx_reg <= in_z * cos_x;
            s1_ysx_reg <= in_y * sin_x;
            s1_x_reg   <= in_x;
            mode_pipe_reg[1] <= vrp_mode_t'(in_data.mode);

            s2_y1_reg <= rot_fin(ROT_SUM_W'(s1_ycx_reg) + ROT_SUM_W'(s1_zsx_reg));
            s2_z1_reg <= rot_fin(ROT_SUM_W'(s1_zcx_reg) - ROT_SUM_W'(s1_ysx_reg));
            s2_x_reg  <= s1_x_reg;

            s3_xcy_reg <= s2_x_reg * cos_y;
            s3_zsy_reg <= s2_z1_reg * sin_y;
            s3_zcy_reg <= s2_z1_reg * cos_y;
            s3_xsy_reg <= s2_x_reg * sin_y;
            s3_y1_reg  <= s2_y1_reg;

            s4_x1_reg <= rot_fin(ROT_SUM_W'(s3_xcy_reg) + ROT_SUM_W'(s3_zsy_reg));
            s4_z_reg  <= rot_fin(ROT_SUM_W'(s3_zcy_reg) - ROT_SUM_W'(s3_xsy_reg));
            s4_y1_reg <= s3_y1_reg;

            s5_xcz_reg <= s4_x1_reg * cos_z;
            s5_ysz_reg <= s4_y1_reg * sin_z;
            s5_xsz_reg <= s4_x1_reg * sin_z;
            s5_ycz_reg <= s4_y1_reg * cos_z;
            s5_z_reg   <= s4_z_reg;

            s6_x_reg <= rot_fin(ROT_SUM_W'(s5_xcz_reg) - ROT_SUM_W'(s5_ysz_reg));
            s6_y_reg <= rot_fin(ROT_SUM_W'(s5_xsz_reg) + ROT_SUM_W'(s5_ycz_reg));
            s6_z_reg <= s5_z_reg;

            // Squared length for the stereographic divisor
            s7_sqx_reg <= s6_x_reg * s6_x_reg;
            s7_sqy_reg <= s6_y_reg * s6_y_reg;
            s7_sqz_reg <= s6_z_reg * s6_z_reg;
            s7_x_reg   <= s6_x_reg;
            s7_y_reg   <= s6_y_reg;
            s7_z_reg   <= s6_z_reg;

            s8_sum_reg       <= SQ_W'(s7_sqx_reg) + SQ_W'(s7_sqy_reg) + SQ_W'(s7_sqz_reg);
            s8_side_reg.x    <= s7_x_reg;
            s8_side_reg.y    <= s7_y_reg;
            s8_side_reg.z    <= s7_z_reg;
            s8_side_reg.mode <= mode_pipe_reg[7];

            for (int i = 2; i <= 7; i++)
            begin
                mode_pipe_reg[i] <= mode_pipe_reg[i-1];
            end
        end
    end

    // Integer square root of the squared length
    vrp_ctl_t                sq_ctl;
    logic [ROOT_W-1:0]       sq_root;
    logic [ROT_SIDE_W-1:0]   sq_side_bits;
    vrp_rot_t                sq_side;

    assign sq_ctl.advance = adv;
    assign sq_ctl.valid   = rv_reg[7];

    vrp_isqrt_pipe #(
        .SIDE_W (ROT_SIDE_W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (sq_ctl),
        .radicand  (s8_sum_reg),
        .in_side   (s8_side_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side_bits)
    );

    assign sq_side = vrp_rot_t'(sq_side_bits);

    // Projection setup, first stage: divisor, dividends, linear products.
    logic signed [ROT_W-1:0]   zp;
    logic signed [ROT_W:0]     pden;
    logic signed [11:0]        kdiv;
    logic signed [LM_W-1:0]    lmx, lmy;
    logic signed [15:0]        lkx, lky;
    logic                      is_persp, is_iso;

    logic signed [NUM_W-1:0]   d0_num_x_reg, d0_num_y_reg;
    logic signed [DEN_SW-1:0]  d0_den_reg;
    logic signed [LPROD_W-1:0] d0_lpx_reg, d0_lpy_reg;
    logic signed [OFF_W-1:0]   d0_offx_reg, d0_offy_reg;
    logic                      d0_err_reg;
    vrp_mode_t                 d0_mode_reg;

    always_comb
    begin
        is_persp = (sq_side.mode == MODE_PERSP);
        is_iso   = (sq_side.mode == MODE_ISO);
        zp       = (sq_side.z == '0) ? ROT_W'(1) : sq_side.z;
        pden     = (ROT_W+1)'(zp) - (ROT_W+1)'(PERSP_DIST);
        kdiv     = is_persp ? 12'(PERSP_SCALE) : 12'(STEREO_SCALE);
        lmx      = is_iso ? LM_W'(sq_side.x) - LM_W'(sq_side.y) : LM_W'(sq_side.z);
        lmy      = is_iso ? LM_W'(sq_side.x) + LM_W'(sq_side.y) : LM_W'(sq_side.z);
        lkx      = is_iso ? 16'(ISO_COS) : 16'(OBL_KX);
        lky      = is_iso ? 16'(ISO_SIN) : 16'(OBL_KY);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d0_num_x_reg <= sq_side.x * kdiv;
            d0_num_y_reg <= sq_side.y * kdiv;
            d0_den_reg   <= is_persp ? DEN_SW'(pden) : DEN_SW'({1'b0, sq_root});
            d0_lpx_reg   <= lmx * lkx;
            d0_lpy_reg   <= lmy * lky;
            d0_offx_reg  <= is_iso ? OFF_W'(CENTRE_X)
                          : OFF_W'(sq_side.x) + OFF_W'(pan_x) + OFF_W'(CENTRE_X);
            d0_offy_reg  <= is_iso ? OFF_W'(CENTRE_Y) - OFF_W'(sq_side.z)
                          : OFF_W'(sq_side.y) + OFF_W'(pan_y) + OFF_W'(CENTRE_Y);
            d0_err_reg   <= (is_persp && pden == '0)
                         || (sq_side.mode == MODE_STEREO && sq_root == '0);
            d0_mode_reg  <= sq_side.mode;
        end
    end

    // Projection setup, second stage: magnitudes, signs, linear results.
    logic                      n0_neg_x, n0_neg_y, n0_neg_d;
    logic signed [NUM_W-1:0]   n0_abs_x, n0_abs_y;
    logic signed [DEN_SW-1:0]  n0_abs_d;
    logic signed [LSUM_W-1:0]  n0_tx, n0_ty;

    logic [QUO_W-1:0]          d1_num_x_reg, d1_num_y_reg;
    logic [DEN_W-1:0]          d1_den_reg;
    vrp_div_side_t             d1_side_reg;

    always_comb
    begin
        n0_neg_x = d0_num_x_reg[NUM_W-1];
        n0_neg_y = d0_num_y_reg[NUM_W-1];
        n0_neg_d = d0_den_reg[DEN_SW-1];
        n0_abs_x = n0_neg_x ? -d0_num_x_reg : d0_num_x_reg;
        n0_abs_y = n0_neg_y ? -d0_num_y_reg : d0_num_y_reg;
        n0_abs_d = n0_neg_d ? -d0_den_reg : d0_den_reg;
        n0_tx    = LSUM_W'(d0_lpx_reg) + (LSUM_W'(d0_offx_reg) <<< PFRAC);
        n0_ty    = LSUM_W'(d0_lpy_reg) + (LSUM_W'(d0_offy_reg) <<< PFRAC);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d1_num_x_reg      <= n0_abs_x[QUO_W-1:0];
            d1_num_y_reg      <= n0_abs_y[QUO_W-1:0];
            d1_den_reg        <= n0_abs_d[DEN_W-1:0];
            d1_side_reg.err   <= d0_err_reg;
            d1_side_reg.mode  <= d0_mode_reg;
            d1_side_reg.neg_x <= n0_neg_x ^ n0_neg_d;
            d1_side_reg.neg_y <= n0_neg_y ^ n0_neg_d;
            d1_side_reg.lin_x <= lin_fin(n0_tx)
                               + ((d0_mode_reg == MODE_ISO) ? LIN_W'(pan_x) : '0);
            d1_side_reg.lin_y <= lin_fin(n0_ty)
                               + ((d0_mode_reg == MODE_ISO) ? LIN_W'(pan_y) : '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d0_valid_reg <= 1'b0;
            d1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            d0_valid_reg <= sq_valid;
            d1_valid_reg <= d0_valid_reg;
        end
    end

    // Division of both screen coordinates by the shared divisor
    vrp_ctl_t              dv_ctl;
    logic [QUO_W-1:0]      dv_quo_x, dv_quo_y;
    logic [DIV_SIDE_W-1:0] dv_side_bits;
    vrp_div_side_t         dv_side;

    assign dv_ctl.advance = adv;
    assign dv_ctl.valid   = d1_valid_reg;

    vrp_div_pipe #(
        .SIDE_W (DIV_SIDE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (dv_ctl),
        .num_a     (d1_num_x_reg),
        .num_b     (d1_num_y_reg),
        .den       (d1_den_reg),
        .in_side   (d1_side_reg),
        .out_valid (dv_valid),
        .quo_a     (dv_quo_x),
        .quo_b     (dv_quo_y),
        .out_side  (dv_side_bits)
    );

    assign dv_side = vrp_div_side_t'(dv_side_bits);

    // Final stage: apply sign, add centre and pan, select, saturate.
    logic signed [FIN_W-1:0] q_x, q_y, f_x, f_y;
    logic                    uses_div;

    always_comb
    begin
        uses_div = (dv_side.mode == MODE_PERSP) || (dv_side.mode == MODE_STEREO);
        q_x = dv_side.neg_x ? -FIN_W'({1'b0, dv_quo_x}) : FIN_W'({1'b0, dv_quo_x});
        q_y = dv_side.neg_y ? -FIN_W'({1'b0, dv_quo_y}) : FIN_W'({1'b0, dv_quo_y});
        if (dv_side.err)
        begin
            f_x = '0;
            f_y = '0;
        end
        else if (uses_div)
        begin
            f_x = q_x + FIN_W'(CENTRE_X) + FIN_W'(pan_x);
            f_y = q_y + FIN_W'(CENTRE_Y) + FIN_W'(pan_y);
        end
        else
        begin
            f_x = FIN_W'(dv_side.lin_x);
            f_y = FIN_W'(dv_side.lin_y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg.screen_x  <= sat_out(f_x);
            out_reg.screen_y  <= sat_out(f_y);
            out_reg.div_error <= dv_side.err;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A flagged division always reports a zero point.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.div_error |->
            out_data.screen_x == '0 && out_data.screen_y == '0)
        else $error("div_error item with nonzero coordinates");

    // During a stall no rotation or projection setup stage may gain or lose an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(rv_reg) && $stable(d0_valid_reg) && $stable(d1_valid_reg))
        else $error("pipeline valid bits moved during a stall");

    // Only perspective and stereographic items can raise the error flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        d1_valid_reg && d1_side_reg.err |->
            d1_side_reg.mode == MODE_PERSP || d1_side_reg.mode == MODE_STEREO)
        else $error("error flag on a projection without division");

endmodule

>>> dv/tb_top.sv
// Testbench for the vertex rotate and project unit: drives vertices under
// random idling, predicts each screen point and compares it field by field.
// Depends on vrp_pkg and vertex_rotate_project_unit.
module tb_top;
    import vrp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 85;
    localparam int CYCLE_LIMIT = 400000;

    // Scoreboard: keeps its own copy of the registers and predicts each point.
    class projection_scoreboard;
        logic signed [15:0] trig [6];
        logic signed [15:0] pan_h;
        logic signed [15:0] pan_v;
        vrp_out_t pending_points [$];
        int mismatches;
        int checked;
        int div_errors;

        function void reset_regs();
            trig[0] = 16384; trig[1] = 0; trig[2] = 16384;
            trig[3] = 0; trig[4] = 16384; trig[5] = 0;
            pan_h = 0;
            pan_v = 0;
        endfunction

        function void write_reg(vrp_cfg_idx_t idx, logic [15:0] val);
            if (idx == CFG_PAN_X) pan_h = val;
            else if (idx == CFG_PAN_Y) pan_v = val;
            else trig[int'(idx)] = val;
        endfunction

        function longint sat(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        // Rotation term in Q.14, truncated toward zero and held to 32 bits.
        function longint turn(longint a, longint ca, longint b, longint cb);
            longint s;
            s = (a * ca + b * cb) / 16384;
            return sat(s, -64'sd2147483648, 64'sd2147483647);
        endfunction

        function longint root_floor(longint unsigned n);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0)
            begin
                if (n >= r + b)
                begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return longint'(r);
        endfunction

        function longint unsigned mag_sq(longint v);
            longint unsigned m;
            m = v < 0 ? -v : v;
            return m * m;
        endfunction

        function void note_vertex(vrp_in_t item);
            longint x, y, z, y1, z1, x1, x2, y2, sx, sy, d;
            longint one;
            bit err;
            vrp_out_t pt;
            one = 16384;
            err = 0;
            sx = 0;
            sy = 0;
            x = item.coord_x;
            y = item.coord_y;
            z = item.coord_z;
            y1 = turn(y, trig[0], z, trig[1]);
            z1 = turn(-y, trig[1], z, trig[0]);
            x1 = turn(x, trig[2], z1, trig[3]);
            z = turn(-x, trig[3], z1, trig[2]);
            x2 = turn(x1, trig[4], -y1, trig[5]);
            y2 = turn(x1, trig[5], y1, trig[4]);
            x = x2;
            y = y2;
            case (vrp_mode_t'(item.mode))
                MODE_PERSP:
                begin
                    if (z == 0) z = 1;
                    d = z - 600;
                    if (d == 0) err = 1;
                    else
                    begin
                        sx = (1000 * x) / d + 860 + pan_h;
                        sy = (1000 * y) / d + 460 + pan_v;
                    end
                end
                MODE_ISO:
                begin
                    sx = ((x - y) * 14189 + 860 * one) / one + pan_h;
                    sy = ((x + y) * 8192 + (460 - z) * one) / one + pan_v;
                end
                MODE_OBLIQUE:
                begin
                    sx = (z * 6905 + (x + pan_h + 860) * one) / one;
                    sy = (z * 4408 + (y + pan_v + 460) * one) / one;
                end
                default:
                begin
                    d = root_floor(mag_sq(x) + mag_sq(y) + mag_sq(z));
                    if (d == 0) err = 1;
                    else
                    begin
                        sx = (x * 300) / d + pan_h + 860;
                        sy = (y * 300) / d + pan_v + 460;
                    end
                end
            endcase
            if (err)
            begin
                sx = 0;
                sy = 0;
            end
            pt.screen_x = 16'(sat(sx, -32768, 32767));
            pt.screen_y = 16'(sat(sy, -32768, 32767));
            pt.div_error = err;
            pending_points.push_back(pt);
        endfunction

        function void check_point(vrp_out_t got);
            vrp_out_t exp_pt;
            if (pending_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected point %p", got);
                return;
            end
            exp_pt = pending_points.pop_front();
            checked++;
            if (got.div_error) div_errors++;
            if (got.screen_x !== exp_pt.screen_x || got.screen_y !== exp_pt.screen_y
                || got.div_error !== exp_pt.div_error)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Point mismatch: expected x=%0d y=%0d err=%0b, got x=%0d y=%0d err=%0b",
                             exp_pt.screen_x, exp_pt.screen_y, exp_pt.div_error,
                             got.screen_x, got.screen_y, got.div_error);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    vrp_in_t in_data;
    logic out_valid;
    logic out_ready;
    vrp_out_t out_data;
    logic cfg_we;
    vrp_cfg_idx_t cfg_addr;
    logic [CFG_W-1:0] cfg_wdata;

    projection_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_off_cycles;
    int cycle_count;

    vertex_rotate_project_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Cycle limit guards against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: check accepted points at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) sb.check_point(out_data);
    end

    // Receiver idling and the long hold-off, changed at the falling edge.
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offers one item and returns at the falling edge after it is accepted;
    // valid stays up so that the next item can follow with no gap.
    task automatic send_vertex(vrp_in_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_vertex(item);
        @(negedge clk);
    endtask

    task automatic send_xyz(int x, int y, int z, vrp_mode_t m);
        vrp_in_t item;
        item.coord_x = 16'(x);
        item.coord_y = 16'(y);
        item.coord_z = 16'(z);
        item.mode = m;
        send_vertex(item);
    endtask

    // Waits for every point and lets the pipeline drain before a write.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_points.size() != 0) @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    // Raises the write enable and waits until it has been sampled; the caller drops it.
    task automatic write_reg(vrp_cfg_idx_t idx, int val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= 16'(val);
        sb.write_reg(idx, 16'(val));
        @(negedge clk);
    endtask

    function automatic int rand_trig(bit extreme);
        if (extreme) return $urandom_range(1) ? 16384 : -16384;
        return $urandom_range(1) ? $urandom_range(32767) - 16384 : int'($urandom) % 32768;
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? 32767 : -32768;
            1: return int'($urandom_range(2000)) - 1000;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    task automatic random_block(int count);
        int k;
        int z;
        for (k = 0; k < count; k++)
        begin
            z = ($urandom_range(15) == 0) ? 600 : rand_coord();
            if ($urandom_range(40) == 0) send_xyz(0, 0, 0, MODE_STEREO);
            else send_xyz(rand_coord(), rand_coord(), z, vrp_mode_t'($urandom_range(3)));
        end
    endtask

    task automatic random_regs(bit extreme);
        int r;
        for (r = 0; r < 6; r++) write_reg(vrp_cfg_idx_t'(r), rand_trig(extreme));
        write_reg(CFG_PAN_X, extreme ? 32767 : int'($urandom_range(65535)) - 32768);
        write_reg(CFG_PAN_Y, extreme ? -32768 : int'($urandom_range(65535)) - 32768);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int m;
        int ph;
        sb = new();
        sb.reset_regs();
        cycle_count = 0;
        hold_off_cycles = 0;
        send_idle_pct = 9;
        recv_idle_pct = 65;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = CFG_COS_X;
        cfg_wdata = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed vertices at reset registers: extremes, every mode, zero divisors.
        for (m = 0; m < 4; m++)
        begin
            send_xyz(32767, -32768, 32767, vrp_mode_t'(m));
            send_xyz(-32768, 32767, -32768, vrp_mode_t'(m));
            send_xyz(5, -7, 0, vrp_mode_t'(m));
        end
        send_xyz(10, 20, 600, MODE_PERSP);
        send_xyz(0, 0, 0, MODE_STEREO);
        send_xyz(0, 0, 1, MODE_PERSP);
        drain();

        // Extreme trig and pan, then a zero divisor after rotation.
        random_regs(1'b1);
        send_xyz(32767, 32767, 32767, MODE_ISO);
        send_xyz(-32768, -32768, -32768, MODE_OBLIQUE);
        send_xyz(0, 0, 0, MODE_STEREO);
        send_xyz(-32768, 32767, -32768, MODE_PERSP);
        drain();

        // Random phases with the three idling profiles.
        for (ph = 0; ph < 6; ph++)
        begin
            if (ph == 2)
            begin
                send_idle_pct = 65;
                recv_idle_pct = 9;
            end
            if (ph == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_regs(ph == 5);
            if (ph == 1) hold_off_cycles = 300;
            random_block(240);
            drain();
        end
        sb.reset_regs();
        write_reg(CFG_COS_X, 16384);
        write_reg(CFG_SIN_X, 0);
        write_reg(CFG_COS_Y, 16384);
        write_reg(CFG_SIN_Y, 0);
        write_reg(CFG_COS_Z, 16384);
        write_reg(CFG_SIN_Z, 0);
        write_reg(CFG_PAN_X, 0);
        write_reg(CFG_PAN_Y, 0);
        cfg_we <= 1'b0;
        random_block(60);
        drain();

        $display("Checked %0d points across four projection modes and eight register settings,",
                 sb.checked);
        $display("including %0d zero-divisor points and a long output stall.", sb.div_errors);
        if (sb.mismatches == 0 && sb.pending_points.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
